[rtl/core/tslp_pkg.sv]
`default_nettype none
package tslp_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD_CENTER = 3'd0,
    REG_THRESHOLD_LEFT   = 3'd1,
    REG_THRESHOLD_RIGHT  = 3'd2,
    REG_LONG_PRESS_MS    = 3'd3,
    REG_BRIGHTNESS_STEP  = 3'd4,
    REG_LEVEL_CEILING    = 3'd5
  } cfg_reg_t;

  localparam logic [15:0] THRESHOLD_RST  = 16'hFFFF;
  localparam logic [15:0] LONG_PRESS_RST = 16'd1200;
  localparam logic [7:0]  STEP_RST       = 8'd5;
  localparam logic [7:0]  MAX_BRIGHT_RST = 8'd255;

  // number of pads that have a threshold register
  localparam logic [1:0]  PAD_LIMIT = 2'd3;

  localparam logic [1:0]  PAD_CENTER = 2'd0;
  localparam logic [1:0]  PAD_LEFT   = 2'd1;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } ramp_dir_t;

  typedef struct packed {
    logic [15:0] threshold_center;
    logic [15:0] threshold_left;
    logic [15:0] threshold_right;
    logic [15:0] long_press_ms;
    logic [7:0]  brightness_step;
    logic [7:0]  level_ceiling;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  pad_index;
    logic [15:0] raw_value;
    logic [31:0] now_ms;
    logic [7:0]  strip_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0] pad_echo;
    logic       toggle_request;
    logic       long_press_start;
    logic       level_valid;
    logic [7:0] new_level;
  } out_item_t;

endpackage
`default_nettype wire

[rtl/core/touch_short_long_press_dimmer_unit.sv]
`default_nettype none
// Touch pad short/long press detector with brightness ramp. Each input
// transaction carries one raw sample of one pad (0 center, 1 left, 2 right),
// a millisecond timestamp and that strip's brightness, and yields exactly one
// result transaction: a toggle request when a short press is released, a flag
// when a long press is first recognised, and a clamped ramp level while the
// pad's ramp runs. Throughput is one transaction per clock unless out_ready
// stalls the output; an accepted input loads the input register, then the
// per-pad state update and result register load together. Per-pad state lives
// in flops and is read and written in the same cycle, so consecutive samples
// of one pad see each other's updates. Configuration is written through
// cfg_we, cfg_index and cfg_wdata; the user must do so only while the unit is
// idle, which the unit itself does not enforce. Unknown indexes are ignored.
module touch_short_long_press_dimmer_unit #(
  parameter int unsigned NUM_PADS = 3
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire tslp_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output tslp_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [tslp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tslp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  tslp_pkg::cfg_t      cfg;
  tslp_pkg::in_item_t  item_r;
  tslp_pkg::out_item_t res;
  tslp_pkg::out_item_t out_data_r;
  logic                item_v_r;
  logic                item_v_nxt;
  logic                out_v_r;
  logic                out_v_nxt;
  logic                adv;

  tslp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tslp_pad_logic #(
    .NUM_PADS (NUM_PADS)
  ) u_pad (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .cfg   (cfg),
    .item  (item_r),
    .res   (res)
  );

  assign adv        = item_v_r && (!out_v_r || out_ready);
  assign in_ready   = !item_v_r || adv;
  assign item_v_nxt = (in_valid && in_ready) || (item_v_r && !adv);
  assign out_v_nxt  = adv || (out_v_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[rtl/core/tslp_cfg_regs.sv]
`default_nettype none
module tslp_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [tslp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tslp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output tslp_pkg::cfg_t                        cfg
);

  tslp_pkg::cfg_t cfg_r;
  tslp_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        tslp_pkg::REG_THRESHOLD_CENTER: cfg_nxt.threshold_center = cfg_wdata;
        tslp_pkg::REG_THRESHOLD_LEFT:   cfg_nxt.threshold_left   = cfg_wdata;
        tslp_pkg::REG_THRESHOLD_RIGHT:  cfg_nxt.threshold_right  = cfg_wdata;
        tslp_pkg::REG_LONG_PRESS_MS:    cfg_nxt.long_press_ms    = cfg_wdata;
        tslp_pkg::REG_BRIGHTNESS_STEP:  cfg_nxt.brightness_step  = cfg_wdata[7:0];
        tslp_pkg::REG_LEVEL_CEILING:    cfg_nxt.level_ceiling    = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold_center <= tslp_pkg::THRESHOLD_RST;
      cfg_r.threshold_left   <= tslp_pkg::THRESHOLD_RST;
      cfg_r.threshold_right  <= tslp_pkg::THRESHOLD_RST;
      cfg_r.long_press_ms    <= tslp_pkg::LONG_PRESS_RST;
      cfg_r.brightness_step  <= tslp_pkg::STEP_RST;
      cfg_r.level_ceiling    <= tslp_pkg::MAX_BRIGHT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

[rtl/core/tslp_pad_logic.sv]
`default_nettype none
module tslp_pad_logic #(
  parameter int unsigned NUM_PADS = 3
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire tslp_pkg::cfg_t     cfg,
  input  wire tslp_pkg::in_item_t item,
  output tslp_pkg::out_item_t     res
);

  // pads without a threshold register hold no state
  localparam int unsigned DEPTH   = (NUM_PADS < 3) ? NUM_PADS : 3;
  localparam int unsigned PIDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [1:0]  DEPTH_L = 2'(DEPTH);

  logic                  held_r  [DEPTH];
  logic                  long_r  [DEPTH];
  logic [31:0]           stamp_r [DEPTH];
  tslp_pkg::ramp_dir_t   dir_r   [DEPTH];

  logic                  held_nxt;
  logic                  long_nxt;
  logic [31:0]           stamp_nxt;
  tslp_pkg::ramp_dir_t   dir_nxt;

  logic [PIDX_W-1:0]     idx;
  logic                  pad_ok;
  logic [15:0]           thr;
  logic                  touched;
  logic [31:0]           held_for;
  logic                  toggle;
  logic                  start;
  logic signed [9:0]     stepped;
  logic signed [9:0]     max_s;
  logic signed [9:0]     clamped;

  assign idx    = item.pad_index[PIDX_W-1:0];
  assign pad_ok = (item.pad_index < DEPTH_L) && (item.pad_index < tslp_pkg::PAD_LIMIT);

  always_comb begin
    case (item.pad_index)
      tslp_pkg::PAD_CENTER: thr = cfg.threshold_center;
      tslp_pkg::PAD_LEFT:   thr = cfg.threshold_left;
      default:              thr = cfg.threshold_right;
    endcase
  end

  assign touched  = item.raw_value < thr;
  assign held_for = item.now_ms - stamp_r[idx];

  always_comb begin
    held_nxt  = held_r[idx];
    long_nxt  = long_r[idx];
    stamp_nxt = stamp_r[idx];
    dir_nxt   = dir_r[idx];
    toggle    = 1'b0;
    start     = 1'b0;
    if (touched) begin
      if (held_r[idx]) begin
        if ((held_for > {16'd0, cfg.long_press_ms}) && !long_r[idx]) begin
          long_nxt = 1'b1;
          start    = 1'b1;
          dir_nxt  = (item.strip_level <= {2'b00, cfg.level_ceiling[7:2]}) ?
                     tslp_pkg::DIR_UP : tslp_pkg::DIR_DOWN;
        end
      end else begin
        held_nxt  = 1'b1;
        stamp_nxt = item.now_ms;
      end
    end else begin
      if (held_r[idx]) begin
        if (!long_r[idx]) begin
          toggle = 1'b1;
        end else begin
          dir_nxt = tslp_pkg::DIR_NONE;
        end
      end
      held_nxt = 1'b0;
      long_nxt = 1'b0;
    end
  end

  // step, limit to max, then raise to at least one
  always_comb begin
    max_s = signed'({2'b00, cfg.level_ceiling});
    if (dir_nxt == tslp_pkg::DIR_UP) begin
      stepped = signed'({2'b00, item.strip_level}) + signed'({2'b00, cfg.brightness_step});
    end else begin
      stepped = signed'({2'b00, item.strip_level}) - signed'({2'b00, cfg.brightness_step});
    end
    clamped = (stepped > max_s) ? max_s : stepped;
    if (clamped < 10'sd1) begin
      clamped = 10'sd1;
    end
  end

  always_comb begin
    res.pad_echo         = item.pad_index;
    res.toggle_request   = pad_ok & toggle;
    res.long_press_start = pad_ok & start;
    res.level_valid      = pad_ok & (dir_nxt != tslp_pkg::DIR_NONE);
    res.new_level        = res.level_valid ? clamped[7:0] : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        held_r[i] <= 1'b0;
        long_r[i] <= 1'b0;
        dir_r[i]  <= tslp_pkg::DIR_NONE;
      end
    end else if (adv && pad_ok) begin
      held_r[idx] <= held_nxt;
      long_r[idx] <= long_nxt;
      dir_r[idx]  <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && pad_ok) begin
      stamp_r[idx] <= stamp_nxt;
    end
  end

endmodule
`default_nettype wire

[bench/touch_short_long_press_dimmer_unit_test.sv]
`default_nettype none
module touch_short_long_press_dimmer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RUN_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 215;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;
  localparam logic [1:0] PAD_RIGHT = 2'd2;
  localparam logic [1:0] PAD_SPARE = 2'd3;

  typedef struct {
    bit                  fixed;
    tslp_pkg::out_item_t result;
  } sample_note_t;

  typedef struct {
    bit                  is_cfg;
    logic [2:0]          reg_idx;
    logic [15:0]         reg_val;
    tslp_pkg::in_item_t  stim;
    bit                  fixed;
    tslp_pkg::out_item_t result;
  } script_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  tslp_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  tslp_pkg::out_item_t out_data;
  logic                cfg_we = 1'b0;
  logic [2:0]          cfg_index = '0;
  logic [15:0]         cfg_wdata = '0;

  // predictor copy of configuration and per-pad press state
  logic [15:0] thr_q [3] = '{tslp_pkg::THRESHOLD_RST, tslp_pkg::THRESHOLD_RST,
                             tslp_pkg::THRESHOLD_RST};
  logic [15:0] hold_ms_q = tslp_pkg::LONG_PRESS_RST;
  logic [7:0]  step_q = tslp_pkg::STEP_RST;
  logic [7:0]  max_q = tslp_pkg::MAX_BRIGHT_RST;
  logic        held_q [3] = '{1'b0, 1'b0, 1'b0};
  logic        long_q [3] = '{1'b0, 1'b0, 1'b0};
  logic [31:0] stamp_q [3] = '{32'd0, 32'd0, 32'd0};
  tslp_pkg::ramp_dir_t dir_q [3] = '{tslp_pkg::DIR_NONE, tslp_pkg::DIR_NONE,
                                     tslp_pkg::DIR_NONE};

  sample_note_t        sent_notes [$];
  tslp_pkg::out_item_t due_outcomes [$];
  script_row_t         script [$];

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  // stimulus shaping state
  bit          pressing [3] = '{1'b0, 1'b0, 1'b0};
  logic [31:0] clock_ms = 32'hFFFF_F000;

  touch_short_long_press_dimmer_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic tslp_pkg::out_item_t press_outcome(tslp_pkg::in_item_t s);
    tslp_pkg::out_item_t r;
    int unsigned         p;
    logic                touched;
    logic [31:0]         held_for;
    int                  lvl;
    r = '0;
    r.pad_echo = s.pad_index;
    if (s.pad_index < tslp_pkg::PAD_LIMIT) begin
      p = 32'(s.pad_index);
      touched = s.raw_value < thr_q[p];
      if (touched) begin
        if (held_q[p]) begin
          held_for = s.now_ms - stamp_q[p];
          if (held_for > {16'd0, hold_ms_q} && !long_q[p]) begin
            long_q[p] = 1'b1;
            r.long_press_start = 1'b1;
            dir_q[p] = (s.strip_level <= (max_q >> 2)) ? tslp_pkg::DIR_UP : tslp_pkg::DIR_DOWN;
          end
        end else begin
          held_q[p] = 1'b1;
          stamp_q[p] = s.now_ms;
        end
      end else begin
        if (held_q[p]) begin
          if (!long_q[p]) begin
            r.toggle_request = 1'b1;
          end else begin
            dir_q[p] = tslp_pkg::DIR_NONE;
          end
        end
        held_q[p] = 1'b0;
        long_q[p] = 1'b0;
      end
      if (dir_q[p] != tslp_pkg::DIR_NONE) begin
        lvl = int'(s.strip_level);
        if (dir_q[p] == tslp_pkg::DIR_UP) begin
          lvl += int'(step_q);
        end else begin
          lvl -= int'(step_q);
        end
        if (lvl > int'(max_q)) lvl = int'(max_q);
        if (lvl < 1) lvl = 1;
        r.level_valid = 1'b1;
        r.new_level = lvl[7:0];
      end
    end
    return r;
  endfunction

  function automatic void cmp_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic script_row_t smp(logic [1:0] pad, logic [15:0] raw, logic [31:0] now,
                                      logic [7:0] lvl, bit fixed, bit tog = 1'b0,
                                      bit st = 1'b0, bit lv = 1'b0, logic [7:0] lev = 8'd0);
    script_row_t r;
    r = '{default: '0};
    r.stim = '{pad_index: pad, raw_value: raw, now_ms: now, strip_level: lvl};
    r.fixed = fixed;
    r.result = '{pad_echo: pad, toggle_request: tog, long_press_start: st,
                 level_valid: lv, new_level: lev};
    return r;
  endfunction

  function automatic script_row_t cfg_row(logic [2:0] idx, logic [15:0] val);
    script_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic tslp_pkg::in_item_t make_sample();
    tslp_pkg::in_item_t s;
    int unsigned        p;
    logic [15:0]        thr;
    p = ($urandom_range(0, 99) < 4) ? 3 : $urandom_range(0, 2);
    s.pad_index = p[1:0];
    if ($urandom_range(0, 99) < 2) begin
      clock_ms = $urandom;
    end else begin
      clock_ms += $urandom_range(0, hold_ms_q / 3 + 4);
    end
    s.now_ms = clock_ms;
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 4))
        0: s.strip_level = 8'd0;
        1: s.strip_level = 8'd255;
        2: s.strip_level = max_q >> 2;
        3: s.strip_level = (max_q >> 2) + 8'd1;
        default: s.strip_level = max_q;
      endcase
    end else begin
      s.strip_level = 8'($urandom_range(0, 255));
    end
    if (p < 3 && $urandom_range(0, 99) < 85) begin
      pressing[p] = pressing[p] ? ($urandom_range(0, 99) < 85) : ($urandom_range(0, 99) < 40);
      thr = thr_q[p];
      if (pressing[p] && thr != 16'd0) begin
        s.raw_value = 16'($urandom_range(0, thr - 1));
      end else begin
        s.raw_value = 16'($urandom_range(thr, 16'hFFFF));
      end
    end else begin
      s.raw_value = 16'($urandom);
    end
    return s;
  endfunction

  task automatic offer_sample(tslp_pkg::in_item_t s, bit fixed, tslp_pkg::out_item_t typed);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    sent_notes.push_back('{fixed, typed});
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_outcomes.size() != 0);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      tslp_pkg::REG_THRESHOLD_CENTER: thr_q[0] = val;
      tslp_pkg::REG_THRESHOLD_LEFT:   thr_q[1] = val;
      tslp_pkg::REG_THRESHOLD_RIGHT:  thr_q[2] = val;
      tslp_pkg::REG_LONG_PRESS_MS:    hold_ms_q = val;
      tslp_pkg::REG_BRIGHTNESS_STEP:  step_q = val[7:0];
      tslp_pkg::REG_LEVEL_CEILING:    max_q = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // receiver side: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      hold_left <= HOLD_OFF_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : scoreboard
    tslp_pkg::out_item_t want;
    sample_note_t        note;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (due_outcomes.size() == 0) begin
          mismatches++;
          $display("%0t unexpected transaction: expected none actual %p", $time, out_data);
        end else begin
          want = due_outcomes.pop_front();
          cmp_field("pad_echo", want.pad_echo, out_data.pad_echo);
          cmp_field("toggle_request", want.toggle_request, out_data.toggle_request);
          cmp_field("long_press_start", want.long_press_start, out_data.long_press_start);
          cmp_field("level_valid", want.level_valid, out_data.level_valid);
          cmp_field("new_level", want.new_level, out_data.new_level);
        end
      end
      if (in_valid && in_ready) begin
        note = sent_notes.pop_front();
        want = press_outcome(in_data);
        due_outcomes.push_back(note.fixed ? note.result : want);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("touch_short_long_press_dimmer_unit_test failed");
      $finish;
    end
  end

  initial begin : stimulus
    bit          prev_cfg;
    logic [15:0] t0, t1, t2, lp, st, mx;
    int unsigned snd, rcv;

    // short press, wrap of the time stamp, clamps, direction boundary
    script.push_back(smp(tslp_pkg::PAD_CENTER, 16'hFFFF, 32'd0, 8'd0, 1));
    script.push_back(smp(PAD_SPARE, 16'h0000, 32'd0, 8'd255, 1));
    script.push_back(smp(tslp_pkg::PAD_CENTER, 16'h0000, 32'd100, 8'd10, 1));
    script.push_back(smp(tslp_pkg::PAD_CENTER, 16'hFFFF, 32'd200, 8'd10, 1, 1));
    script.push_back(smp(tslp_pkg::PAD_LEFT, 16'h0000, 32'hFFFF_FF00, 8'd0, 1));
    script.push_back(smp(tslp_pkg::PAD_LEFT, 16'h0000, 32'h0000_0400, 8'd0, 1, 0, 1, 1, 8'd5));
    script.push_back(smp(tslp_pkg::PAD_LEFT, 16'd100, 32'h0000_0800, 8'd253, 1, 0, 0, 1,
                         8'd255));
    script.push_back(smp(tslp_pkg::PAD_LEFT, 16'hFFFF, 32'h0000_0900, 8'd255, 1));
    script.push_back(smp(PAD_RIGHT, 16'h0000, 32'd5000, 8'd200, 1));
    script.push_back(smp(PAD_RIGHT, 16'h0000, 32'd6200, 8'd200, 1));
    script.push_back(smp(PAD_RIGHT, 16'h0000, 32'd6201, 8'd200, 1, 0, 1, 1, 8'd195));
    script.push_back(smp(PAD_RIGHT, 16'h0000, 32'd7000, 8'd3, 1, 0, 0, 1, 8'd1));
    script.push_back(smp(PAD_RIGHT, 16'hFFFF, 32'd7100, 8'd3, 1));
    script.push_back(smp(tslp_pkg::PAD_CENTER, 16'h0000, 32'd0, 8'd63, 1));
    script.push_back(smp(tslp_pkg::PAD_CENTER, 16'h0001, 32'hFFFF_FFFF, 8'd63, 1, 0, 1, 1,
                         8'd68));
    script.push_back(smp(tslp_pkg::PAD_CENTER, 16'hFFFE, 32'd0, 8'd68, 1, 0, 0, 1, 8'd73));
    script.push_back(smp(tslp_pkg::PAD_CENTER, 16'hFFFF, 32'd10, 8'd73, 1));
    // zero step, zero max and zero hold time, then unknown indexes
    script.push_back(cfg_row(tslp_pkg::REG_BRIGHTNESS_STEP, 16'd0));
    script.push_back(cfg_row(tslp_pkg::REG_LEVEL_CEILING, 16'd0));
    script.push_back(cfg_row(tslp_pkg::REG_LONG_PRESS_MS, 16'd0));
    script.push_back(cfg_row(REG_SPARE_6, 16'hFFFF));
    script.push_back(smp(tslp_pkg::PAD_LEFT, 16'h0000, 32'd50, 8'd100, 0));
    script.push_back(smp(tslp_pkg::PAD_LEFT, 16'h0000, 32'd51, 8'd100, 1, 0, 1, 1, 8'd1));
    script.push_back(smp(tslp_pkg::PAD_LEFT, 16'h0000, 32'd51, 8'd0, 1, 0, 0, 1, 8'd1));
    script.push_back(smp(tslp_pkg::PAD_LEFT, 16'hFFFF, 32'd60, 8'd0, 1));
    script.push_back(cfg_row(tslp_pkg::REG_THRESHOLD_LEFT, 16'd0));
    script.push_back(cfg_row(REG_SPARE_7, 16'h5A5A));
    script.push_back(smp(tslp_pkg::PAD_LEFT, 16'h0000, 32'd70, 8'd0, 1));
    script.push_back(smp(PAD_RIGHT, 16'h8000, 32'd80, 8'd128, 0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    prev_cfg = 1'b0;
    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        if (!prev_cfg) settle();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        if (prev_cfg) cfg_we <= 1'b0;
        offer_sample(script[i].stim, script[i].fixed, script[i].result);
      end
      prev_cfg = script[i].is_cfg;
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          t0 = 16'h8000; t1 = 16'h8000; t2 = 16'h8000;
          lp = 16'd1200; st = 16'd5; mx = 16'd255; snd = 0; rcv = 0;
        end
        1: begin
          t0 = 16'hFFFF; t1 = 16'hFFFF; t2 = 16'hFFFF;
          lp = 16'd0; st = 16'd255; mx = 16'd255; snd = 69; rcv = 0;
        end
        2: begin
          t0 = 16'h0000; t1 = 16'h1234; t2 = 16'hFFFF;
          lp = 16'hFFFF; st = 16'd1; mx = 16'd1; snd = 0; rcv = 69;
        end
        3: begin
          t0 = 16'($urandom); t1 = 16'($urandom); t2 = 16'($urandom);
          lp = 16'($urandom_range(0, 300)); st = 16'd0; mx = 16'd0; snd = 30; rcv = 30;
        end
        4: begin
          t0 = 16'($urandom_range(16'h4000, 16'hFFFF));
          t1 = 16'($urandom_range(16'h4000, 16'hFFFF));
          t2 = 16'($urandom_range(16'h4000, 16'hFFFF));
          lp = 16'($urandom_range(0, 3000));
          st = {8'($urandom), 8'($urandom_range(1, 255))};
          mx = {8'($urandom), 8'($urandom_range(1, 255))};
          snd = 0; rcv = 0;
        end
        default: begin
          t0 = 16'($urandom); t1 = 16'($urandom); t2 = 16'($urandom);
          lp = 16'($urandom_range(0, 2000));
          st = {8'($urandom), 8'($urandom_range(1, 255))};
          mx = {8'($urandom), 8'($urandom_range(1, 255))};
          snd = 69; rcv = 30;
        end
      endcase
      settle();
      write_reg(tslp_pkg::REG_THRESHOLD_CENTER, t0);
      write_reg(tslp_pkg::REG_THRESHOLD_LEFT, t1);
      write_reg(tslp_pkg::REG_THRESHOLD_RIGHT, t2);
      write_reg(tslp_pkg::REG_LONG_PRESS_MS, lp);
      write_reg(tslp_pkg::REG_BRIGHTNESS_STEP, st);
      write_reg(tslp_pkg::REG_LEVEL_CEILING, mx);
      if (ph == 5) write_reg(REG_SPARE_7, 16'($urandom));
      cfg_we <= 1'b0;
      send_idle_pct = snd;
      recv_stall_pct = rcv;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == 20) hold_asked++;
        if ((ph == 2 && n == 100) || $urandom_range(0, 99) == 0) settle();
        offer_sample(make_sample(), 1'b0, '0);
      end
    end

    settle();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("touch_short_long_press_dimmer_unit_test passed");
    end else begin
      $display("touch_short_long_press_dimmer_unit_test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
